### rtl/t64x_pkg.sv
// Shared types and constants for the 64-bit timer extender.
// Used by t64x_core and timer_64bit_extender_top; no dependencies.
package t64x_pkg;

   // Default number of hardware comparators
   localparam int TIMER_COUNT_DEFAULT = 3;

   localparam int SLOT_W   = 3;
   localparam int WORD_W   = 32;
   localparam int TICKS_W  = 64;
   localparam int REQ_W    = 2;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_DATA_W = 104;   // ticks 64 + counter 32 + irq 1 -> 97
   localparam int RSP_DATA_W = 104;   // value 64 + cw 1 + cv 32 + ch 1 + ci 1 -> 99

   // Compare value reserved to mark a 32-bit counter rollover
   localparam logic [WORD_W-1:0] ROLLOVER_MARK = 32'h0000_0001;

   // Request kinds
   localparam logic [REQ_W-1:0] REQ_COMPARE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SET     = 2'd2;

   // Configuration register indexes
   localparam logic CSR_TIMER_SLOT = 1'b0;
   localparam logic CSR_HANDLER    = 1'b1;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [TICKS_W-1:0] deadline_ticks;
      logic [WORD_W-1:0]  counter_low;
      logic               irq_pending;
   } req_type_s_type;

   typedef struct packed {
      logic               status;
      logic [TICKS_W-1:0] value_out;
      logic               compare_write;
      logic [WORD_W-1:0]  compare_value;
      logic               call_handler;
      logic               clear_irq;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] upper_count;
      logic [WORD_W-1:0] deadline_high;
      logic [WORD_W-1:0] deadline_low;
      logic [WORD_W-1:0] compare_shadow;
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] timer_slot;
      logic              handler_present;
   } cfg_type;

endpackage

### rtl/t64x_core.sv
// Request decode and next-state logic of the 64-bit timer extender.
// Purely combinational; depends on t64x_pkg.
module t64x_core #(
   parameter int TIMER_COUNT = t64x_pkg::TIMER_COUNT_DEFAULT
) (
   input  t64x_pkg::req_type_s_type req,
   input  t64x_pkg::cfg_type        cfg,
   input  t64x_pkg::state_type      state,
   output t64x_pkg::state_type      state_next,
   output logic                     state_we,
   output t64x_pkg::rsp_type        rsp
);

   logic                             slot_bad;
   logic [t64x_pkg::WORD_W-1:0]      upper_inc;
   logic                             rollover;
   logic [t64x_pkg::WORD_W-1:0]      set_hi;
   logic [t64x_pkg::WORD_W-1:0]      set_lo;
   logic [t64x_pkg::WORD_W-1:0]      cmp_next;
   logic [t64x_pkg::WORD_W-1:0]      set_cmp;

   // Slots at or above the comparator count are invalid
   assign slot_bad  = {1'b0, cfg.timer_slot} >= (t64x_pkg::SLOT_W + 1)'(TIMER_COUNT);
   assign upper_inc = state.upper_count + 32'd1;
   assign rollover  = state.compare_shadow == t64x_pkg::ROLLOVER_MARK;

   // Skip the reserved low value: a low word of one becomes two
   assign set_hi  = req.deadline_ticks[63:32];
   assign set_lo  = (req.deadline_ticks[31:0] == t64x_pkg::ROLLOVER_MARK) ?
                    32'd2 : req.deadline_ticks[31:0];
   assign set_cmp = (state.upper_count < set_hi) ? t64x_pkg::ROLLOVER_MARK : set_lo;

   // Compare event reprogram value, judged against the updated upper word
   always_comb begin
      if (rollover) begin
         cmp_next = (state.deadline_high == upper_inc) ?
                    state.deadline_low : t64x_pkg::ROLLOVER_MARK;
      end else begin
         cmp_next = (state.deadline_high == state.upper_count) ?
                    state.deadline_low : t64x_pkg::ROLLOVER_MARK;
      end
   end

   // Decode the request
   always_comb begin
      state_next = state;
      state_we   = 1'b0;
      rsp        = '0;
      if (slot_bad) begin
         rsp.status = 1'b1;
      end else begin
         unique case (req.req_type)
            t64x_pkg::REQ_COMPARE: begin
               state_we                  = 1'b1;
               state_next.compare_shadow = cmp_next;
               if (rollover) begin
                  state_next.upper_count = upper_inc;
                  rsp.clear_irq          = 1'b1;
               end else begin
                  rsp.call_handler = cfg.handler_present;
               end
               rsp.compare_write = 1'b1;
               rsp.compare_value = cmp_next;
            end
            t64x_pkg::REQ_READ: begin
               rsp.value_out = {((req.irq_pending && rollover) ?
                                 upper_inc : state.upper_count), req.counter_low};
            end
            t64x_pkg::REQ_SET: begin
               if (set_hi < state.upper_count) begin
                  rsp.status = 1'b1;
               end else begin
                  state_we                  = 1'b1;
                  state_next.deadline_high  = set_hi;
                  state_next.deadline_low   = set_lo;
                  state_next.compare_shadow = set_cmp;
                  rsp.value_out             = {set_hi, set_lo};
                  rsp.compare_write         = 1'b1;
                  rsp.compare_value         = set_cmp;
               end
            end
            default: begin
               rsp.status = 1'b1;
            end
         endcase
      end
   end

endmodule

### rtl/timer_64bit_extender_top.sv
// Top level of the 64-bit timer extender: stream ports, request and result
// registers, timer state. Depends on t64x_pkg and t64x_core.
//
// Usage:
//   A request enters on the req_ channel (tuser carries the request kind,
//   tdata the deadline, sampled counter and pending flag). Each request gives
//   exactly one result on the rsp_ channel (tuser carries status).
//   Requests kinds: compare event, read time, set deadline.
//   A request waits in the request register; decode and state update load
//   the result register when it is free or its result is being taken.
//   Throughput is one request per cycle while the receiver does not stall;
//   the timer state words update in the same cycle a request leaves the
//   request register, so the next request sees them at once.
//   When the receiver stalls, the result register holds; the request register
//   still accepts one more request, and req_tready drops only when both are
//   full and rsp_tready is low. Reset clears all state words, the configuration
//   and both valid flags. Configuration is written through csr_; the user must
//   do so only while no request is in flight; the block does not check it.
module timer_64bit_extender_top #(
   parameter int TIMER_COUNT = t64x_pkg::TIMER_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: deadline_ticks[63:0], counter_low[95:64], irq_pending[96], zero pad
   input  logic [t64x_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: req_type[1:0]
   input  logic [t64x_pkg::REQ_W-1:0]        req_tuser,
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: value_out[63:0], compare_write[64], compare_value[96:65],
   //        call_handler[97], clear_irq[98], zero pad
   output logic [t64x_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: status[0]
   output logic                              rsp_tuser,
   // Configuration write port
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [t64x_pkg::SLOT_W-1:0]       csr_wdata
);

   logic                      in_valid_ff, in_valid_in;
   t64x_pkg::req_type_s_type  in_req_ff, in_req_in;
   logic                      out_valid_ff, out_valid_in;
   t64x_pkg::rsp_type         out_rsp_ff, out_rsp_in;
   t64x_pkg::state_type       state_ff, state_in;
   t64x_pkg::cfg_type         cfg_ff, cfg_in;
   t64x_pkg::state_type       core_state;
   logic                      core_we;
   logic                      req_accept;
   logic                      advance;

   // Move the held request forward when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Unpack the incoming request
   always_comb begin
      in_req_in                = in_req_ff;
      if (req_accept) begin
         in_req_in.req_type       = req_tuser;
         in_req_in.deadline_ticks = req_tdata[63:0];
         in_req_in.counter_low    = req_tdata[95:64];
         in_req_in.irq_pending    = req_tdata[96];
      end
   end

   // Request register valid
   always_comb begin
      priority if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   t64x_core #(
      .TIMER_COUNT(TIMER_COUNT)
   ) u_core (
      .req        (in_req_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (core_state),
      .state_we   (core_we),
      .rsp        (out_rsp_in)
   );

   // Result register valid: load on advance, drop when taken
   always_comb begin
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Commit timer state as the request leaves the request register
   assign state_in = (advance && core_we) ? core_state : state_ff;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            t64x_pkg::CSR_TIMER_SLOT: cfg_in.timer_slot      = csr_wdata;
            t64x_pkg::CSR_HANDLER:    cfg_in.handler_present = csr_wdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   // Pack the result
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_rsp_ff.status;
   assign rsp_tdata  = {5'd0,
                        out_rsp_ff.clear_irq,
                        out_rsp_ff.call_handler,
                        out_rsp_ff.compare_value,
                        out_rsp_ff.compare_write,
                        out_rsp_ff.value_out};

endmodule

### dv/tb_timer_64bit_extender_top.sv
// Testbench for timer_64bit_extender_top: directed and random requests under
// several slot/handler settings, results checked against a built-in timer model.
// Depends on t64x_pkg and the RTL of timer_64bit_extender_top.
`timescale 1ns / 1ps

module tb_timer_64bit_extender_top;
   import t64x_pkg::*;

   localparam int SLOTS = TIMER_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_PRINTED = 40;
   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

   // Timer model: shadows the extender state and queues the results it owes
   class timer_scoreboard;
      logic [SLOT_W-1:0] slot;
      logic              handler;
      logic [WORD_W-1:0] upper_count;
      logic [WORD_W-1:0] deadline_high;
      logic [WORD_W-1:0] deadline_low;
      logic [WORD_W-1:0] compare_shadow;
      rsp_type           timer_results_due[$];
      int                errors;

      function new();
         slot = '0;
         handler = 1'b0;
         upper_count = '0;
         deadline_high = '0;
         deadline_low = '0;
         compare_shadow = '0;
         errors = 0;
      endfunction

      function void set_config(logic [SLOT_W-1:0] new_slot, logic new_handler);
         slot = new_slot;
         handler = new_handler;
      endfunction

      function int pending();
         return timer_results_due.size();
      endfunction

      task report(string what, logic [TICKS_W-1:0] got, logic [TICKS_W-1:0] want);
         if (errors < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
         errors++;
      endtask

      // Work out the result of one accepted request and advance the state
      function void note_request(logic [REQ_W-1:0] kind, logic [TICKS_W-1:0] ticks,
                                 logic [WORD_W-1:0] low, logic irq);
         rsp_type            r;
         logic [WORD_W-1:0]  hi;
         logic [WORD_W-1:0]  next_cmp;
         logic [TICKS_W-1:0] adjusted;
         r = '0;
         if (slot >= SLOTS) begin
            r.status = 1'b1;
         end else begin
            case (kind)
               REQ_COMPARE: begin
                  // rollover mark: bump the upper word, else hand off to the user
                  if (compare_shadow == ROLLOVER_MARK) begin
                     upper_count = upper_count + 1;
                     r.clear_irq = 1'b1;
                  end else begin
                     r.call_handler = handler;
                  end
                  next_cmp = (deadline_high == upper_count) ? deadline_low : ROLLOVER_MARK;
                  compare_shadow = next_cmp;
                  r.compare_write = 1'b1;
                  r.compare_value = next_cmp;
               end
               REQ_READ: begin
                  hi = upper_count;
                  if (irq && compare_shadow == ROLLOVER_MARK)
                     hi = hi + 1;
                  r.value_out = {hi, low};
               end
               REQ_SET: begin
                  // skip the reserved low word, reject past high words
                  adjusted = ticks;
                  if (ticks[WORD_W-1:0] == ROLLOVER_MARK)
                     adjusted = ticks + 1;
                  hi = ticks[TICKS_W-1:WORD_W];
                  if (hi < upper_count) begin
                     r.status = 1'b1;
                  end else begin
                     next_cmp = (upper_count < hi) ? ROLLOVER_MARK : adjusted[WORD_W-1:0];
                     deadline_high = hi;
                     deadline_low = adjusted[WORD_W-1:0];
                     compare_shadow = next_cmp;
                     r.value_out = adjusted;
                     r.compare_write = 1'b1;
                     r.compare_value = next_cmp;
                  end
               end
               default: begin
                  r.status = 1'b1;
               end
            endcase
         end
         timer_results_due.push_back(r);
      endfunction

      // Compare one result with the oldest one due
      task check_result(rsp_type got);
         rsp_type want;
         if (timer_results_due.size() == 0) begin
            report("unexpected result", got.value_out, '0);
         end else begin
            want = timer_results_due.pop_front();
            if (got.status !== want.status)
               report("status", got.status, want.status);
            if (got.value_out !== want.value_out)
               report("value_out", got.value_out, want.value_out);
            if (got.compare_write !== want.compare_write)
               report("compare_write", got.compare_write, want.compare_write);
            if (got.compare_value !== want.compare_value)
               report("compare_value", got.compare_value, want.compare_value);
            if (got.call_handler !== want.call_handler)
               report("call_handler", got.call_handler, want.call_handler);
            if (got.clear_irq !== want.clear_irq)
               report("clear_irq", got.clear_irq, want.clear_irq);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic                  csr_index = 1'b0;
   logic [SLOT_W-1:0]     csr_wdata = '0;

   timer_scoreboard sb = new();
   bit              calm = 1'b0;
   int              cycles = 0;
   int              stall_left = 0;

   timer_64bit_extender_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Stall the result side in random bursts, none once the run turns calm
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tuser, rsp_tdata[63:0], rsp_tdata[64], rsp_tdata[96:65],
                          rsp_tdata[97], rsp_tdata[98]});
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timer_64bit_extender_top verification failed");
         $finish;
      end
   end

   // Present one request, hold it until accepted, then log it with the model
   task send_request(logic [REQ_W-1:0] kind, logic [TICKS_W-1:0] ticks,
                     logic [WORD_W-1:0] low, logic irq);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - 97){1'b0}}, irq, low, ticks};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, ticks, low, irq);
   endtask

   // Drop valid and wait until every result due has come back
   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write both registers while idle
   task set_config(logic [SLOT_W-1:0] slot, logic handler);
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMER_SLOT;
      csr_wdata <= slot;
      @(posedge clock);
      csr_index <= CSR_HANDLER;
      csr_wdata <= {{(SLOT_W - 1){1'b0}}, handler};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(slot, handler);
   endtask

   // Pick a request; deadlines mostly land around the current upper word
   task pick_request(output logic [REQ_W-1:0] kind, output logic [TICKS_W-1:0] ticks,
                     output logic [WORD_W-1:0] low, output logic irq);
      int                roll;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
      roll  = $urandom_range(0, 99);
      ticks = {$urandom, $urandom};
      low   = $urandom;
      irq   = $urandom_range(0, 1);
      if (roll < 38) begin
         kind = REQ_COMPARE;
      end else if (roll < 60) begin
         kind = REQ_READ;
         case ($urandom_range(0, 5))
            0: low = '0;
            1: low = '1;
            default: ;
         endcase
      end else if (roll < 97) begin
         kind = REQ_SET;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: hi = sb.upper_count + $urandom_range(0, 3);
            6, 7: hi = sb.upper_count - $urandom_range(1, 2);
            8: hi = sb.upper_count;
            default: hi = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0: lo = '0;
            1: lo = ROLLOVER_MARK;
            2: lo = '1;
            default: lo = $urandom;
         endcase
         ticks = {hi, lo};
      end else begin
         kind = REQ_UNKNOWN;
      end
   endtask

   task run_random(int count);
      logic [REQ_W-1:0]   kind;
      logic [TICKS_W-1:0] ticks;
      logic [WORD_W-1:0]  low;
      logic               irq;
      for (int i = 0; i < count; i++) begin
         pick_request(kind, ticks, low, irq);
         send_request(kind, ticks, low, irq);
         if ($urandom_range(0, 149) == 0)
            drain();
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reads at the extremes, rollover, reserved low word, past deadline
      set_config(3'd0, 1'b0);
      send_request(REQ_READ, '0, 32'h0000_0000, 1'b0);
      send_request(REQ_READ, '1, 32'hffff_ffff, 1'b1);
      send_request(REQ_COMPARE, '0, '0, 1'b0);
      send_request(REQ_SET, 64'h0000_0001_0000_0001, '0, 1'b0);
      send_request(REQ_READ, '0, 32'h1234_5678, 1'b1);
      send_request(REQ_READ, '0, 32'h1234_5678, 1'b0);
      send_request(REQ_COMPARE, '0, '0, 1'b1);
      send_request(REQ_COMPARE, '0, '0, 1'b0);
      send_request(REQ_SET, 64'h0000_0000_0000_0000, '0, 1'b0);
      send_request(REQ_SET, 64'h0000_0001_0000_0001, '0, 1'b0);
      send_request(REQ_SET, 64'hffff_ffff_ffff_ffff, '0, 1'b0);
      send_request(REQ_COMPARE, '0, '0, 1'b0);
      send_request(REQ_READ, '0, 32'h0000_0001, 1'b1);
      send_request(REQ_UNKNOWN, '1, '1, 1'b1);
      send_request(REQ_SET, 64'h0000_0002_ffff_ffff, '0, 1'b0);
      send_request(REQ_COMPARE, '0, '0, 1'b0);
      drain();

      // Handler registered: a deadline event now calls it
      set_config(3'd0, 1'b1);
      send_request(REQ_COMPARE, '0, '0, 1'b0);
      send_request(REQ_SET, 64'h0000_0002_0000_0010, '0, 1'b0);
      send_request(REQ_COMPARE, '0, '0, 1'b0);
      drain();

      // Invalid slots: first one at the count, then the highest
      set_config(3'(SLOTS), 1'b1);
      send_request(REQ_COMPARE, '0, '0, 1'b0);
      send_request(REQ_READ, '0, 32'hdead_beef, 1'b1);
      send_request(REQ_SET, 64'h0000_0009_0000_0009, '0, 1'b0);
      drain();
      set_config(3'd7, 1'b0);
      send_request(REQ_UNKNOWN, '0, '0, 1'b0);
      send_request(REQ_READ, '1, '1, 1'b1);
      drain();

      // Random phases over several settings; the last one runs without random gaps or result stalls
      set_config(3'd0, 1'b1);
      run_random(300);
      set_config(3'(SLOTS - 1), 1'b0);
      run_random(300);
      set_config(3'd1, 1'b1);
      run_random(300);
      set_config(3'd5, 1'b1);
      run_random(30);
      calm = 1'b1;
      set_config(3'd0, 1'b0);
      run_random(270);

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("timer_64bit_extender_top verification clean");
      end else begin
         $display("timer_64bit_extender_top verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/t64x_pkg.sv
rtl/t64x_core.sv
rtl/timer_64bit_extender_top.sv
dv/tb_timer_64bit_extender_top.sv
